// ===== hw/rtl/bsm_pkg.sv =====
// Shared widths, payload types and pipeline constants of the sphere merge block.
package bsm_pkg;

   localparam int unsigned AXES       = 3;
   localparam int unsigned COORD_W    = 32;
   localparam int unsigned RADIUS_W   = 31;
   localparam int unsigned SUM_W      = 32;
   localparam int unsigned SQUARE_W   = 64;
   localparam int unsigned DIFF2_W    = 62;
   localparam int unsigned DIST2_W    = 66;
   localparam int unsigned ROOT_W     = 33;
   localparam int unsigned SQRT_REM_W = 35;
   localparam int unsigned PROD_W     = 65;
   localparam int unsigned QUOT_W     = 32;
   localparam int unsigned DIV_REM_W  = 33;
   localparam int unsigned GROWTH_W   = 62;

   localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

   typedef logic [COORD_W-1:0]  coord_type;
   typedef logic [RADIUS_W-1:0] radius_type;

   typedef struct packed {
      coord_type [AXES-1:0] a_center;
      coord_type [AXES-1:0] b_center;
      radius_type           a_radius;
      radius_type           b_radius;
   } pair_type;

   // Data that rides along the square root pipeline.
   typedef struct packed {
      logic                 overlap;
      logic                 contain;
      logic [AXES-1:0]      neg;
      coord_type [AXES-1:0] mag;
      pair_type             pair;
   } sqrt_side_type;

   // Data that rides along the divider pipeline.
   typedef struct packed {
      logic               overlap;
      logic               contain;
      logic               move;
      logic               keep_a;
      logic [AXES-1:0]    neg;
      logic [ROOT_W-1:0]  r_final;
      pair_type           pair;
   } div_side_type;

endpackage

// ===== hw/rtl/bounding_sphere_merge.sv =====
// Top level of the enclosing sphere merge pipeline.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   two spheres: A and B centers and radii
//   rsp      out        rsp_valid/rsp_stall   overlap, merged sphere, saturation flag, growth
//
// A new pair may be transferred in every cycle while req_stall is low; each result passes
// through four setup stages, 33 square root stages, two stages for radius and products,
// 32 divider stages, two stages for selection and squares, and the output register.
// Reset is synchronous and clears only valid bits; the block has no state between items.
// When rsp stalls, a skid register catches the item leaving the pipeline and req_stall
// then freezes the whole pipeline until the skid register drains.
module bounding_sphere_merge import bsm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COORD_W-1:0]  req_a_center_x,
   input  logic signed [COORD_W-1:0]  req_a_center_y,
   input  logic signed [COORD_W-1:0]  req_a_center_z,
   input  logic [RADIUS_W-1:0]        req_a_radius,
   input  logic signed [COORD_W-1:0]  req_b_center_x,
   input  logic signed [COORD_W-1:0]  req_b_center_y,
   input  logic signed [COORD_W-1:0]  req_b_center_z,
   input  logic [RADIUS_W-1:0]        req_b_radius,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_overlap,
   output logic signed [COORD_W-1:0]  rsp_merged_center_x,
   output logic signed [COORD_W-1:0]  rsp_merged_center_y,
   output logic signed [COORD_W-1:0]  rsp_merged_center_z,
   output logic [RADIUS_W-1:0]        rsp_merged_radius,
   output logic                       rsp_radius_saturated,
   output logic [GROWTH_W-1:0]        rsp_growth
);

   typedef struct packed {
      logic                 overlap;
      coord_type [AXES-1:0] center;
      radius_type           radius;
      logic                 saturated;
      logic [GROWTH_W-1:0]  growth;
   } result_type;

   logic enable;

   // Stage 1: center offsets and radius sum and difference.
   pair_type             pair_in;
   logic [AXES-1:0]      neg_in;
   coord_type [AXES-1:0] mag_in;
   logic                 p1_valid_ff;
   pair_type             p1_pair_ff;
   logic [AXES-1:0]      p1_neg_ff;
   coord_type [AXES-1:0] p1_mag_ff;
   logic [SUM_W-1:0]     p1_sum_ff;
   radius_type           p1_diff_ff;

   // Stage 2: squares.
   logic                            p2_valid_ff;
   pair_type                        p2_pair_ff;
   logic [AXES-1:0]                 p2_neg_ff;
   coord_type [AXES-1:0]            p2_mag_ff;
   logic [AXES-1:0][SQUARE_W-1:0]   p2_sq_ff;
   logic [SQUARE_W-1:0]             p2_sum2_ff;
   logic [DIFF2_W-1:0]              p2_diff2_ff;

   // Stage 3: squared center distance.
   logic [DIST2_W-1:0]   dist2_in;
   logic                 p3_valid_ff;
   pair_type             p3_pair_ff;
   logic [AXES-1:0]      p3_neg_ff;
   coord_type [AXES-1:0] p3_mag_ff;
   logic [DIST2_W-1:0]   p3_dist2_ff;
   logic [SQUARE_W-1:0]  p3_sum2_ff;
   logic [DIFF2_W-1:0]   p3_diff2_ff;

   // Stage 4: overlap and containment tests.
   sqrt_side_type        p4_side_in;
   logic                 p4_valid_ff;
   logic [DIST2_W-1:0]   p4_dist2_ff;
   sqrt_side_type        p4_side_ff;

   logic                 sq_valid;
   logic [ROOT_W-1:0]    sq_root;
   sqrt_side_type        sq_side;

   // Stage 5: merged radius and center shift factor.
   logic [ROOT_W:0]      r_sum;
   logic [ROOT_W-1:0]    r_merge;
   logic [ROOT_W-1:0]    ra_ext;
   logic [ROOT_W-1:0]    rb_ext;
   div_side_type         p5_side_in;
   logic [ROOT_W-1:0]    p5_rmove_in;
   logic                 p5_valid_ff;
   logic [ROOT_W-1:0]    p5_root_ff;
   logic [ROOT_W-1:0]    p5_rmove_ff;
   coord_type [AXES-1:0] p5_mag_ff;
   div_side_type         p5_side_ff;

   // Stage 6: dividends of the center shift.
   logic                            p6_valid_ff;
   logic [AXES-1:0][PROD_W-1:0]     p6_prod_ff;
   logic [ROOT_W-1:0]               p6_root_ff;
   div_side_type                    p6_side_ff;

   logic                            dv_valid;
   logic [AXES-1:0][QUOT_W-1:0]     dv_quot;
   div_side_type                    dv_side;

   // Stage 7: center selection and radius clamp.
   coord_type [AXES-1:0] center_in;
   logic                 sat_in;
   logic                 p7_valid_ff;
   logic                 p7_overlap_ff;
   coord_type [AXES-1:0] p7_center_ff;
   radius_type           p7_rc_ff;
   logic                 p7_sat_ff;
   radius_type           p7_ra_ff;

   // Stage 8: squared radii for the growth.
   logic                 p8_valid_ff;
   logic                 p8_overlap_ff;
   coord_type [AXES-1:0] p8_center_ff;
   radius_type           p8_rc_ff;
   logic                 p8_sat_ff;
   logic                 p8_ge_ff;
   logic [GROWTH_W-1:0]  p8_rc2_ff;
   logic [GROWTH_W-1:0]  p8_ra2_ff;

   result_type           fin_result;
   logic                 pipe_done;
   result_type           out_ff;
   logic                 out_valid_ff;
   result_type           skid_ff;
   logic                 skid_valid_ff;

   assign enable    = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ---------------- stage 1 ----------------
   always_comb begin
      pair_in.a_center = {req_a_center_z, req_a_center_y, req_a_center_x};
      pair_in.b_center = {req_b_center_z, req_b_center_y, req_b_center_x};
      pair_in.a_radius = req_a_radius;
      pair_in.b_radius = req_b_radius;
   end

   for (genvar l = 0; l < AXES; l++) begin : g_offset
      logic [COORD_W:0] off;
      logic [COORD_W:0] absv;
      assign off       = {pair_in.b_center[l][COORD_W-1], pair_in.b_center[l]}
                       - {pair_in.a_center[l][COORD_W-1], pair_in.a_center[l]};
      assign absv      = off[COORD_W] ? ((COORD_W+1)'(0) - off) : off;
      assign neg_in[l] = off[COORD_W];
      assign mag_in[l] = absv[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
         p6_valid_ff <= 1'b0;
         p7_valid_ff <= 1'b0;
         p8_valid_ff <= 1'b0;
      end else if (enable) begin
         p1_valid_ff <= req_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= sq_valid;
         p6_valid_ff <= p5_valid_ff;
         p7_valid_ff <= dv_valid;
         p8_valid_ff <= p7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p1_pair_ff <= pair_in;
         p1_neg_ff  <= neg_in;
         p1_mag_ff  <= mag_in;
         p1_sum_ff  <= {1'b0, req_a_radius} + {1'b0, req_b_radius};
         p1_diff_ff <= (req_a_radius > req_b_radius) ? (req_a_radius - req_b_radius)
                                                     : (req_b_radius - req_a_radius);
      end
   end

   // ---------------- stage 2 ----------------
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int l = 0; l < AXES; l++) begin
            p2_sq_ff[l] <= {32'd0, p1_mag_ff[l]} * {32'd0, p1_mag_ff[l]};
         end
         p2_sum2_ff  <= {32'd0, p1_sum_ff} * {32'd0, p1_sum_ff};
         p2_diff2_ff <= {31'd0, p1_diff_ff} * {31'd0, p1_diff_ff};
         p2_pair_ff  <= p1_pair_ff;
         p2_neg_ff   <= p1_neg_ff;
         p2_mag_ff   <= p1_mag_ff;
      end
   end

   // ---------------- stage 3 ----------------
   always_comb begin
      dist2_in = '0;
      for (int l = 0; l < AXES; l++) begin
         dist2_in = dist2_in + {2'b00, p2_sq_ff[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p3_dist2_ff <= dist2_in;
         p3_sum2_ff  <= p2_sum2_ff;
         p3_diff2_ff <= p2_diff2_ff;
         p3_pair_ff  <= p2_pair_ff;
         p3_neg_ff   <= p2_neg_ff;
         p3_mag_ff   <= p2_mag_ff;
      end
   end

   // ---------------- stage 4 ----------------
   always_comb begin
      p4_side_in.overlap = (p3_dist2_ff <= {2'b00, p3_sum2_ff});
      p4_side_in.contain = (p3_dist2_ff <= {4'b0000, p3_diff2_ff});
      p4_side_in.neg     = p3_neg_ff;
      p4_side_in.mag     = p3_mag_ff;
      p4_side_in.pair    = p3_pair_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p4_dist2_ff <= p3_dist2_ff;
         p4_side_ff  <= p4_side_in;
      end
   end

   bsm_sqrt_pipe u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (p4_valid_ff),
      .in_radicand (p4_dist2_ff),
      .in_side     (p4_side_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // ---------------- stage 5 ----------------
   assign ra_ext  = {2'b00, sq_side.pair.a_radius};
   assign rb_ext  = {2'b00, sq_side.pair.b_radius};
   assign r_sum   = {1'b0, sq_root} + {1'b0, ra_ext} + {1'b0, rb_ext};
   assign r_merge = r_sum[ROOT_W:1];

   always_comb begin
      p5_side_in.overlap = sq_side.overlap;
      p5_side_in.contain = sq_side.contain;
      p5_side_in.keep_a  = (sq_side.pair.a_radius > sq_side.pair.b_radius);
      // A's center moves only when neither sphere contains the other, the centers differ and the radius really grew.
      p5_side_in.move    = !sq_side.contain && (sq_root != '0) && (r_merge > ra_ext);
      p5_side_in.neg     = sq_side.neg;
      p5_side_in.pair    = sq_side.pair;
      if (sq_side.contain) begin
         p5_side_in.r_final = p5_side_in.keep_a ? ra_ext : rb_ext;
      end else begin
         p5_side_in.r_final = r_merge;
      end
      p5_rmove_in = p5_side_in.move ? (r_merge - ra_ext) : '0;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p5_root_ff  <= sq_root;
         p5_rmove_ff <= p5_rmove_in;
         p5_mag_ff   <= sq_side.mag;
         p5_side_ff  <= p5_side_in;
      end
   end

   // ---------------- stage 6 ----------------
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int l = 0; l < AXES; l++) begin
            p6_prod_ff[l] <= {33'd0, p5_mag_ff[l]} * {32'd0, p5_rmove_ff};
         end
         p6_root_ff <= p5_root_ff;
         p6_side_ff <= p5_side_ff;
      end
   end

   bsm_div_pipe u_div (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (p6_valid_ff),
      .in_dividend (p6_prod_ff),
      .in_divisor  (p6_root_ff),
      .in_side     (p6_side_ff),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_side    (dv_side)
   );

   // ---------------- stage 7 ----------------
   always_comb begin
      for (int l = 0; l < AXES; l++) begin
         if (dv_side.contain) begin
            center_in[l] = dv_side.keep_a ? dv_side.pair.a_center[l] : dv_side.pair.b_center[l];
         end else if (dv_side.move) begin
            center_in[l] = dv_side.neg[l] ? (dv_side.pair.a_center[l] - dv_quot[l])
                                          : (dv_side.pair.a_center[l] + dv_quot[l]);
         end else begin
            center_in[l] = dv_side.pair.a_center[l];
         end
      end
      sat_in = (dv_side.r_final[ROOT_W-1:RADIUS_W] != '0);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p7_overlap_ff <= dv_side.overlap;
         p7_center_ff  <= center_in;
         p7_rc_ff      <= sat_in ? RADIUS_MAX : dv_side.r_final[RADIUS_W-1:0];
         p7_sat_ff     <= sat_in;
         p7_ra_ff      <= dv_side.pair.a_radius;
      end
   end

   // ---------------- stage 8 ----------------
   always_ff @(posedge clock) begin
      if (enable) begin
         p8_overlap_ff <= p7_overlap_ff;
         p8_center_ff  <= p7_center_ff;
         p8_rc_ff      <= p7_rc_ff;
         p8_sat_ff     <= p7_sat_ff;
         p8_ge_ff      <= (p7_rc_ff >= p7_ra_ff);
         p8_rc2_ff     <= {31'd0, p7_rc_ff} * {31'd0, p7_rc_ff};
         p8_ra2_ff     <= {31'd0, p7_ra_ff} * {31'd0, p7_ra_ff};
      end
   end

   always_comb begin
      fin_result.overlap   = p8_overlap_ff;
      fin_result.center    = p8_center_ff;
      fin_result.radius    = p8_rc_ff;
      fin_result.saturated = p8_sat_ff;
      fin_result.growth    = p8_ge_ff ? (p8_rc2_ff - p8_ra2_ff) : '0;
   end

   // ---------------- output register and skid ----------------
   assign pipe_done = p8_valid_ff && enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_ff  <= skid_valid_ff || pipe_done;
         skid_valid_ff <= 1'b0;
      end else if (pipe_done) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         out_ff <= skid_valid_ff ? skid_ff : fin_result;
      end else if (pipe_done) begin
         skid_ff <= fin_result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_overlap          = out_ff.overlap;
   assign rsp_merged_center_x  = out_ff.center[0];
   assign rsp_merged_center_y  = out_ff.center[1];
   assign rsp_merged_center_z  = out_ff.center[2];
   assign rsp_merged_radius    = out_ff.radius;
   assign rsp_radius_saturated = out_ff.saturated;
   assign rsp_growth           = out_ff.growth;

endmodule

// ===== hw/rtl/bsm_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
module bsm_sqrt_pipe import bsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [DIST2_W-1:0]  in_radicand,
   input  sqrt_side_type       in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output sqrt_side_type       out_side
);

   localparam int unsigned STEPS = ROOT_W;

   logic                  valid_ff [0:STEPS-1];
   logic [SQRT_REM_W-1:0] rem_ff   [0:STEPS-1];
   logic [ROOT_W-1:0]     root_ff  [0:STEPS-1];
   logic [DIST2_W-1:0]    rad_ff   [0:STEPS-1];
   sqrt_side_type         side_ff  [0:STEPS-1];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic                  cur_valid;
      logic [SQRT_REM_W-1:0] cur_rem;
      logic [ROOT_W-1:0]     cur_root;
      logic [DIST2_W-1:0]    cur_rad;
      sqrt_side_type         cur_side;
      logic [SQRT_REM_W+1:0] acc;
      logic [SQRT_REM_W+1:0] trial;
      logic [SQRT_REM_W+1:0] diff;
      logic                  take;

      if (k == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_rem   = '0;
         assign cur_root  = '0;
         assign cur_rad   = in_radicand;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[k-1];
         assign cur_rem   = rem_ff[k-1];
         assign cur_root  = root_ff[k-1];
         assign cur_rad   = rad_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      // Bring down the next two radicand bits and try the candidate 4*root+1.
      assign acc   = {cur_rem, cur_rad[DIST2_W-1 -: 2]};
      assign trial = {2'b00, cur_root, 2'b01};
      assign diff  = acc - trial;
      assign take  = (acc >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= take ? diff[SQRT_REM_W-1:0] : acc[SQRT_REM_W-1:0];
            root_ff[k] <= {cur_root[ROOT_W-2:0], take};
            rad_ff[k]  <= {cur_rad[DIST2_W-3:0], 2'b00};
            side_ff[k] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// ===== hw/rtl/bsm_div_pipe.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module bsm_div_pipe import bsm_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             in_valid,
   input  logic [AXES-1:0][PROD_W-1:0]      in_dividend,
   input  logic [ROOT_W-1:0]                in_divisor,
   input  div_side_type                     in_side,
   output logic                             out_valid,
   output logic [AXES-1:0][QUOT_W-1:0]      out_quot,
   output div_side_type                     out_side
);

   localparam int unsigned STEPS = QUOT_W;

   logic                              valid_ff [0:STEPS-1];
   logic [AXES-1:0][DIV_REM_W-1:0]    rem_ff   [0:STEPS-1];
   logic [AXES-1:0][QUOT_W-1:0]       low_ff   [0:STEPS-1];
   logic [AXES-1:0][QUOT_W-1:0]       quot_ff  [0:STEPS-1];
   logic [ROOT_W-1:0]                 dvsr_ff  [0:STEPS-1];
   div_side_type                      side_ff  [0:STEPS-1];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic                           cur_valid;
      logic [AXES-1:0][DIV_REM_W-1:0] cur_rem;
      logic [AXES-1:0][QUOT_W-1:0]    cur_low;
      logic [AXES-1:0][QUOT_W-1:0]    cur_quot;
      logic [ROOT_W-1:0]              cur_dvsr;
      div_side_type                   cur_side;
      logic [AXES-1:0][DIV_REM_W-1:0] rem_in;
      logic [AXES-1:0]                take;

      if (k == 0) begin : g_first
         // The quotient fits in QUOT_W bits, so the upper dividend bits already lie below the divisor.
         for (genvar l = 0; l < AXES; l++) begin : g_lane
            assign cur_rem[l] = in_dividend[l][PROD_W-1:QUOT_W];
            assign cur_low[l] = in_dividend[l][QUOT_W-1:0];
         end
         assign cur_valid = in_valid;
         assign cur_quot  = '0;
         assign cur_dvsr  = in_divisor;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[k-1];
         assign cur_rem   = rem_ff[k-1];
         assign cur_low   = low_ff[k-1];
         assign cur_quot  = quot_ff[k-1];
         assign cur_dvsr  = dvsr_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      for (genvar l = 0; l < AXES; l++) begin : g_lane_step
         logic [DIV_REM_W:0] acc;
         logic [DIV_REM_W:0] diff;
         assign acc        = {cur_rem[l], cur_low[l][QUOT_W-1]};
         assign diff       = acc - {1'b0, cur_dvsr};
         assign take[l]    = (acc >= {1'b0, cur_dvsr});
         assign rem_in[l]  = take[l] ? diff[DIV_REM_W-1:0] : acc[DIV_REM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            for (int l = 0; l < AXES; l++) begin
               low_ff[k][l]  <= {cur_low[l][QUOT_W-2:0], 1'b0};
               quot_ff[k][l] <= {cur_quot[l][QUOT_W-2:0], take[l]};
            end
            rem_ff[k]  <= rem_in;
            dvsr_ff[k] <= cur_dvsr;
            side_ff[k] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quot  = quot_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// ===== hw/rtl/bsm_checker.sv =====
// Port-level checks of the sphere merge block and their binding to the top level.
module bsm_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [31:0]  rsp_merged_center_x,
   input logic [30:0]         rsp_merged_radius,
   input logic                rsp_radius_saturated,
   input logic [61:0]         rsp_growth
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_merged_center_x)
                                 && $stable(rsp_merged_radius) && $stable(rsp_growth))
      else $error("stalled result changed");

   // The input side is only held off while a result waits on the output side.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

   // A clamped radius sits at the largest code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_radius_saturated |-> rsp_merged_radius == '1)
      else $error("saturated radius not at maximum");

   // Reset empties the pipeline and the skid register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("results or stall present after reset");

endmodule

bind bounding_sphere_merge bsm_checker u_checker (.*);

// ===== test/bounding_sphere_merge_tb.sv =====
// Self-checking testbench of the enclosing sphere merge block.
module bounding_sphere_merge_tb;
   import bsm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LATENCY = 74;
   localparam longint unsigned CYCLE_LIMIT = 400000;

   typedef struct {
      logic             overlap;
      coord_type        cx, cy, cz;
      radius_type       radius;
      logic             saturated;
      logic [GROWTH_W-1:0] growth;
   } merge_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_a_center_x = '0, req_a_center_y = '0, req_a_center_z = '0;
   logic signed [COORD_W-1:0] req_b_center_x = '0, req_b_center_y = '0, req_b_center_z = '0;
   logic [RADIUS_W-1:0] req_a_radius = '0, req_b_radius = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_overlap;
   logic signed [COORD_W-1:0] rsp_merged_center_x, rsp_merged_center_y, rsp_merged_center_z;
   logic [RADIUS_W-1:0] rsp_merged_radius;
   logic rsp_radius_saturated;
   logic [GROWTH_W-1:0] rsp_growth;

   merge_result_type expected_merges[$];
   int unsigned error_count = 0;
   int unsigned result_count = 0;
   int unsigned sent_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   longint unsigned cycle_count = 0;

   bounding_sphere_merge DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[bounding_sphere_merge] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   // Exact enclosing sphere, done with wide integer arithmetic.
   function automatic merge_result_type merge_spheres(
      coord_type ax, coord_type ay, coord_type az, radius_type ra_in,
      coord_type bx, coord_type by, coord_type bz, radius_type rb_in);
      merge_result_type r;
      logic signed [33:0] off[3];
      logic signed [33:0] acen[3], bcen[3];
      logic [33:0] mag;
      logic [67:0] dist2;
      logic [67:0] sum2, diff2;
      logic [33:0] ra, rb, diff;
      logic [67:0] root, cand;
      logic [67:0] big_r, clamped;
      logic [127:0] prod;
      logic [67:0] quot;
      logic signed [67:0] cen[3];
      acen[0] = $signed(ax); acen[1] = $signed(ay); acen[2] = $signed(az);
      bcen[0] = $signed(bx); bcen[1] = $signed(by); bcen[2] = $signed(bz);
      ra = ra_in;
      rb = rb_in;
      dist2 = '0;
      for (int i = 0; i < 3; i++) begin
         off[i] = bcen[i] - acen[i];
         mag = off[i][33] ? -off[i] : off[i];
         dist2 = dist2 + mag * mag;
      end
      sum2 = (ra + rb) * (ra + rb);
      r.overlap = dist2 <= sum2;
      diff = ra > rb ? ra - rb : rb - ra;
      diff2 = diff * diff;
      if (dist2 <= diff2) begin
         for (int i = 0; i < 3; i++) cen[i] = ra > rb ? acen[i] : bcen[i];
         big_r = ra > rb ? ra : rb;
      end else begin
         root = '0;
         // The candidate square needs more than 68 bits for the top bits.
         for (int b = 40; b >= 0; b--) begin
            cand = root | (68'd1 << b);
            if (136'(cand) * 136'(cand) <= 136'(dist2)) root = cand;
         end
         big_r = (root + ra + rb) >> 1;
         for (int i = 0; i < 3; i++) begin
            cen[i] = acen[i];
            if (root > 0 && big_r > ra) begin
               mag = off[i][33] ? -off[i] : off[i];
               prod = 128'(mag) * 128'(big_r - ra);
               quot = 68'(prod / 128'(root));
               cen[i] = off[i][33] ? acen[i] - $signed(quot) : acen[i] + $signed(quot);
            end
         end
      end
      clamped = big_r > 68'(RADIUS_MAX) ? 68'(RADIUS_MAX) : big_r;
      r.saturated = big_r > 68'(RADIUS_MAX);
      r.cx = cen[0][31:0];
      r.cy = cen[1][31:0];
      r.cz = cen[2][31:0];
      r.radius = clamped[30:0];
      r.growth = clamped >= ra ? GROWTH_W'(clamped * clamped - ra * ra) : '0;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("mismatch on %s at result %0d: got %h, expected %h",
               what, result_count, got, want);
   endtask

   always @(posedge clock) begin
      merge_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_merges.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            e = expected_merges.pop_front();
            if (rsp_overlap !== e.overlap) report_mismatch("overlap", rsp_overlap, e.overlap);
            if (rsp_merged_center_x !== e.cx)
               report_mismatch("center x", rsp_merged_center_x, e.cx);
            if (rsp_merged_center_y !== e.cy)
               report_mismatch("center y", rsp_merged_center_y, e.cy);
            if (rsp_merged_center_z !== e.cz)
               report_mismatch("center z", rsp_merged_center_z, e.cz);
            if (rsp_merged_radius !== e.radius)
               report_mismatch("radius", rsp_merged_radius, e.radius);
            if (rsp_radius_saturated !== e.saturated)
               report_mismatch("saturated", rsp_radius_saturated, e.saturated);
            if (rsp_growth !== e.growth) report_mismatch("growth", rsp_growth, e.growth);
         end
         result_count++;
      end
   end

   // Presents one pair and holds it until the transfer happens.
   task automatic send_pair(coord_type ax, coord_type ay, coord_type az, radius_type ra,
                            coord_type bx, coord_type by, coord_type bz, radius_type rb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_center_x <= ax; req_a_center_y <= ay; req_a_center_z <= az;
      req_a_radius <= ra;
      req_b_center_x <= bx; req_b_center_y <= by; req_b_center_z <= bz;
      req_b_radius <= rb;
      do @(posedge clock); while (req_stall);
      expected_merges.push_back(merge_spheres(ax, ay, az, ra, bx, by, bz, rb));
      sent_count++;
   endtask

   function automatic coord_type random_coord();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $signed($urandom_range(2000000)) - 1000000;
      endcase
   endfunction

   function automatic radius_type random_radius();
      case ($urandom_range(4))
         0: return radius_type'($urandom);
         1: return $urandom_range(1) ? RADIUS_MAX : '0;
         default: return radius_type'($urandom_range(1500000));
      endcase
   endfunction

   task automatic test_extremes();
      send_pair(0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(0, 0, 0, 100, 0, 0, 0, 100);
      send_pair(1, 2, 3, 500, 1, 2, 3, 200);
      send_pair(0, 0, 0, 65536, 300, 0, 0, 65536);
      send_pair(0, 0, 0, 10, 5000, 0, 0, 20);
      send_pair(0, 0, 0, 1000, 0, 200, 0, 3000);
      send_pair(0, 0, 0, 3000, 0, 200, 0, 1000);
      send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 0, RADIUS_MAX,
                32'h8000_0000, 32'h7FFF_FFFF, 0, RADIUS_MAX);
      send_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, RADIUS_MAX,
                32'h7FFF_FFFF, 0, 32'h8000_0000, 0);
      send_pair(0, 0, 0, RADIUS_MAX, 0, 0, 0, RADIUS_MAX);
      send_pair(-7, 9, -11, 3, 13, -17, 19, 5);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
   endtask

   task automatic test_random(int unsigned count);
      coord_type ax, ay, az;
      for (int unsigned n = 0; n < count; n++) begin
         ax = random_coord(); ay = random_coord(); az = random_coord();
         if ($urandom_range(3) == 0)
            send_pair(ax, ay, az, random_radius(), ax + $urandom_range(255),
                      ay - $urandom_range(255), az, random_radius());
         else
            send_pair(ax, ay, az, random_radius(), random_coord(), random_coord(),
                      random_coord(), random_radius());
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 35;
      recv_idle_pct = 83;
      test_extremes();
      test_random(480);
      send_idle_pct = 83;
      recv_idle_pct = 35;
      test_random(480);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(540);
      while (expected_merges.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d sphere pairs and checked %0d merged spheres,", sent_count,
               result_count);
      $display("covering containment, coincident centers and radius saturation.");
      if (error_count == 0) begin
         $display("[bounding_sphere_merge] OK");
      end else begin
         $display("[bounding_sphere_merge] ERROR");
      end
      $finish;
   end

endmodule
